// File: src/xdrop_affine_gapped_extension_defines.svh
// Assertion macros used by the port-level checker of the gapped extension block.
`ifndef XDROP_AFFINE_GAPPED_EXTENSION_DEFINES_SVH
`define XDROP_AFFINE_GAPPED_EXTENSION_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define XAGE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("xage assertion failed");

// Clocked assertion that also holds while reset is applied.
`define XAGE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("xage assertion failed during reset");

`endif

// File: src/xage_pkg.sv
// Types, constants and codes of the X-drop affine gapped extension block.
package xage_pkg;

	localparam int MaxQueryDefault   = 256;
	localparam int MaxSubjectDefault = 1024;
	localparam int AlphabetDefault   = 32;
	localparam int ScoreBitsDefault  = 24;

	localparam logic [7:0]  OpenGapReset   = 8'd11;
	localparam logic [7:0]  ExtendGapReset = 8'd1;
	localparam logic [15:0] DropoffReset   = 16'd38;

	// Traceback codes.
	localparam logic [5:0] TR_M_FROM_M       = 6'd0;
	localparam logic [5:0] TR_M_FROM_IX      = 6'd1;
	localparam logic [5:0] TR_M_FROM_IY      = 6'd2;
	localparam logic [5:0] TR_IX_FROM_IX     = 6'd4;
	localparam logic [5:0] TR_IX_FROM_IX_1ST = 6'd5;
	localparam logic [5:0] TR_IY_FROM_IY     = 6'd32;
	localparam logic [5:0] TR_M_IY_FROM_IY   = 6'd34;

	typedef enum logic [1:0] {
		CMD_LOAD_SUBJECT = 2'd0,
		CMD_LOAD_PROFILE = 2'd1,
		CMD_START        = 2'd2,
		CMD_READ_TRACE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_OPEN_GAP   = 2'd0,
		CFG_EXTEND_GAP = 2'd1,
		CFG_DROPOFF    = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RB,
		ST_SUB,
		ST_PROF,
		ST_CALC,
		ST_POST,
		ST_ROW,
		ST_TCHK,
		ST_TAIL
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [7:0]         query_index;
		logic [9:0]         subject_index;
		logic [4:0]         residue;
		logic signed [15:0] score;
		logic [8:0]         query_length;
		logic [10:0]        subject_length;
	} req_t;

	typedef struct packed {
		logic [22:0] best_score;
		logic [7:0]  best_query;
		logic [9:0]  best_subject;
		logic [5:0]  trace_code;
		logic        is_readback;
	} rsp_t;

endpackage

// File: src/xdrop_affine_gapped_extension.sv
// Load commands write their store on acceptance; a readback answer is registered in ST_RB.
// A start runs one sequencer over the pruned cells: each cell that reads the profile
// steps through subject read, profile read, compute and best/drop update, tail cells
// are written in the tail state, and each row ends in the row state.
// The block takes no new transaction until its result is taken.
// Reset clears control state and the best result, and loads the gap/dropoff defaults.
module xdrop_affine_gapped_extension
	import xage_pkg::*;
#(
	parameter int MAX_QUERY   = MaxQueryDefault,
	parameter int MAX_SUBJECT = MaxSubjectDefault,
	parameter int ALPHABET    = AlphabetDefault,
	parameter int SCORE_BITS  = ScoreBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  xage_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output xage_pkg::rsp_t     rsp,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import xage_pkg::*;

	localparam int SB  = SCORE_BITS;
	localparam int SW  = $clog2(MAX_SUBJECT);
	localparam int SC  = $clog2(MAX_SUBJECT + 1);
	localparam int QW  = $clog2(MAX_QUERY);
	localparam int QC  = $clog2(MAX_QUERY + 1);
	localparam int PD  = MAX_QUERY * ALPHABET;
	localparam int PAW = $clog2(PD);
	localparam int TD  = MAX_QUERY * MAX_SUBJECT;
	localparam int TAW = $clog2(TD);
	localparam int CW  = SB + SW + 12;

	localparam logic signed [CW-1:0] SatMax = CW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] SatMin = CW'(-(64'sd1 <<< (SB - 1)));
	localparam logic signed [SB-1:0] Filler = {2'b11, {(SB - 2){1'b0}}};

	function automatic logic signed [SB-1:0] sat(input logic signed [CW-1:0] v);
		logic signed [SB-1:0] r;
		if (v > SatMax) r = SatMax[SB-1:0];
		else if (v < SatMin) r = SatMin[SB-1:0];
		else r = v[SB-1:0];
		return r;
	endfunction

	state_t state_q, state_d;

	logic [7:0]  open_q, ext_q;
	logic [15:0] drop_q;
	logic [QC-1:0] lq_q, q_q;
	logic [SC-1:0] ls_q, c_q, cstart_q, rend_q;
	logic [TAW-1:0] tbase_q;
	logic [PAW-1:0] pbase_q;
	logic left_q, first_q, subbig_q;
	logic signed [SB-1:0] best_q, thr_q, pm_q, pis_q, pom_q, poq_q, pos_q;
	logic signed [SB-1:0] om_q, oq_q, os_q, m_q, iq_q, is_q;
	logic signed [CW-1:0] pen_q;
	logic [QW-1:0] bq_q;
	logic [SW-1:0] bs_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic rb_oob_q;

	// RAM ports
	logic [4:0] sub_rd;
	logic [15:0] prof_rd;
	logic [SB-1:0] m_rd, iq_rd, is_rd;
	logic [5:0] tr_rd;
	logic sub_we, prof_we, row_we, tr_we;
	logic [SW-1:0] sub_waddr, c_idx;
	logic [PAW-1:0] prof_waddr, prof_raddr;
	logic [TAW-1:0] tr_waddr, tr_raddr;
	logic signed [SB-1:0] m_wd, iq_wd, is_wd;
	logic [5:0] t_wd;

	logic accept;
	logic rsp_take;
	logic row0;
	logic signed [CW-1:0] prof_w, ext_w, open_w, drop_w;
	logic signed [SB-1:0] a_ext, b_open, c_ext, d_open, sel;
	logic [QC-1:0] lq_in;
	logic [SC-1:0] ls_in;
	logic [SC-1:0] c_inc;
	logic row_go, tail_go, tail_stop, row0_brk;

	assign accept    = req_valid && !req_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign row0      = (q_q == '0);
	assign c_idx     = c_q[SW-1:0];
	assign c_inc     = c_q + SC'(1);

	assign prof_w = subbig_q ? '0 : CW'($signed(prof_rd));
	assign ext_w  = CW'($signed({1'b0, ext_q}));
	assign open_w = CW'($signed({1'b0, open_q}));
	assign drop_w = CW'($signed({1'b0, drop_q}));

	always_comb begin
		if (req.query_length == '0) lq_in = QC'(1);
		else if (req.query_length > MAX_QUERY) lq_in = QC'(MAX_QUERY);
		else lq_in = QC'(req.query_length);
		if (req.subject_length == '0) ls_in = SC'(1);
		else if (req.subject_length > MAX_SUBJECT) ls_in = SC'(MAX_SUBJECT);
		else ls_in = SC'(req.subject_length);
	end

	xage_ram #(.WIDTH(5), .DEPTH(MAX_SUBJECT)) u_subject (
		.clk, .we(sub_we), .waddr(sub_waddr), .wdata(req.residue),
		.raddr(c_idx), .rdata(sub_rd)
	);
	xage_ram #(.WIDTH(16), .DEPTH(PD)) u_profile (
		.clk, .we(prof_we), .waddr(prof_waddr), .wdata(req.score),
		.raddr(prof_raddr), .rdata(prof_rd)
	);
	xage_ram #(.WIDTH(SB), .DEPTH(MAX_SUBJECT)) u_match (
		.clk, .we(row_we), .waddr(c_idx), .wdata(m_wd), .raddr(c_idx), .rdata(m_rd)
	);
	xage_ram #(.WIDTH(SB), .DEPTH(MAX_SUBJECT)) u_insq (
		.clk, .we(row_we), .waddr(c_idx), .wdata(iq_wd), .raddr(c_idx), .rdata(iq_rd)
	);
	xage_ram #(.WIDTH(SB), .DEPTH(MAX_SUBJECT)) u_inss (
		.clk, .we(row_we), .waddr(c_idx), .wdata(is_wd), .raddr(c_idx), .rdata(is_rd)
	);
	xage_ram #(.WIDTH(6), .DEPTH(TD)) u_trace (
		.clk, .we(tr_we), .waddr(tr_waddr), .wdata(t_wd), .raddr(tr_raddr), .rdata(tr_rd)
	);

	assign sub_waddr  = SW'(req.subject_index);
	assign prof_waddr = PAW'(int'(req.query_index) * ALPHABET + int'(req.residue));
	assign prof_raddr = pbase_q + PAW'(sub_rd);
	assign tr_waddr   = tbase_q + TAW'(c_idx);
	assign tr_raddr   = TAW'(int'(req.query_index) * MAX_SUBJECT + int'(req.subject_index));

	// Cell arithmetic; only one mode is live in a given cycle.
	always_comb begin
		a_ext  = '0;
		b_open = '0;
		c_ext  = '0;
		d_open = '0;
		sel    = '0;
		m_wd   = Filler;
		iq_wd  = Filler;
		is_wd  = Filler;
		t_wd   = TR_M_FROM_M;
		if (state_q == ST_TAIL) begin
			is_wd = sat(CW'(pis_q) - ext_w);
			t_wd  = TR_IX_FROM_IX;
		end else if (row0) begin
			if (c_q == '0) begin
				m_wd = sat(prof_w);
			end else begin
				m_wd   = sat(prof_w - pen_q);
				a_ext  = sat(CW'(pis_q) - ext_w);
				b_open = sat(CW'(pm_q) - open_w);
				if (a_ext > b_open) begin
					is_wd = a_ext;
					t_wd  = TR_IX_FROM_IX_1ST;
				end else begin
					is_wd = b_open;
					t_wd  = TR_M_FROM_IX;
				end
			end
		end else if (first_q) begin
			a_ext  = sat(CW'(oq_q) - ext_w);
			b_open = sat(CW'(om_q) - open_w);
			if (a_ext > b_open) begin
				iq_wd = a_ext;
				t_wd  = TR_M_IY_FROM_IY;
			end else begin
				iq_wd = b_open;
				t_wd  = TR_M_FROM_IY;
			end
		end else begin
			if (pom_q >= poq_q) begin
				if (pom_q >= pos_q) begin
					sel = pom_q; t_wd = TR_M_FROM_M;
				end else begin
					sel = pos_q; t_wd = TR_M_FROM_IX;
				end
			end else begin
				if (poq_q >= pos_q) begin
					sel = poq_q; t_wd = TR_M_FROM_IY;
				end else begin
					sel = pos_q; t_wd = TR_M_FROM_IX;
				end
			end
			m_wd   = sat(prof_w + CW'(sel));
			a_ext  = sat(CW'(oq_q) - ext_w);
			b_open = sat(CW'(om_q) - open_w);
			if (b_open >= a_ext) begin
				iq_wd = b_open;
			end else begin
				iq_wd = a_ext;
				t_wd  = t_wd | TR_IY_FROM_IY;
			end
			c_ext  = sat(CW'(pis_q) - ext_w);
			d_open = sat(CW'(pm_q) - open_w);
			if (d_open >= c_ext) begin
				is_wd = d_open;
			end else begin
				is_wd = c_ext;
				t_wd  = t_wd | TR_IX_FROM_IX;
			end
		end
	end

	assign row_go    = (q_q < lq_q) && (rend_q > cstart_q);
	assign tail_go   = !((thr_q > pm_q) && (thr_q > pis_q) && (thr_q > iq_q)) && (c_q < ls_q);
	assign tail_stop = (thr_q > is_wd) || (c_inc >= ls_q);
	assign row0_brk  = (thr_q > m_q) && (thr_q > is_q);

	// Next state and RAM strobes.
	always_comb begin
		state_d = state_q;
		sub_we  = 1'b0;
		prof_we = 1'b0;
		row_we  = 1'b0;
		tr_we   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.cmd)
						CMD_LOAD_SUBJECT: sub_we = (req.subject_index < MAX_SUBJECT);
						CMD_LOAD_PROFILE: prof_we = (req.query_index < MAX_QUERY) &&
							(req.residue < ALPHABET);
						CMD_START:        state_d = ST_SUB;
						CMD_READ_TRACE:   state_d = ST_RB;
						default:          state_d = ST_IDLE;
					endcase
				end
			end
			ST_RB:   state_d = ST_IDLE;
			ST_SUB:  state_d = ST_PROF;
			ST_PROF: state_d = ST_CALC;
			ST_CALC: begin
				row_we  = 1'b1;
				tr_we   = 1'b1;
				state_d = ST_POST;
			end
			ST_POST: begin
				if (row0) begin
					if ((c_q != '0) && row0_brk) state_d = ST_ROW;
					else if (c_inc < ls_q) state_d = ST_SUB;
					else state_d = ST_ROW;
				end else if (c_inc < rend_q) begin
					state_d = ST_SUB;
				end else begin
					state_d = ST_TCHK;
				end
			end
			ST_ROW:  state_d = row_go ? ST_SUB : ST_IDLE;
			ST_TCHK: state_d = tail_go ? ST_TAIL : ST_ROW;
			ST_TAIL: begin
				row_we = 1'b1;
				tr_we  = 1'b1;
				if (tail_stop) state_d = ST_ROW;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control, best result and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= OpenGapReset;
			ext_q       <= ExtendGapReset;
			drop_q      <= DropoffReset;
			rsp_valid_q <= 1'b0;
			best_q      <= '0;
			bq_q        <= '0;
			bs_q        <= '0;
			thr_q       <= '0;
			q_q         <= '0;
			c_q         <= '0;
			cstart_q    <= '0;
			rend_q      <= '0;
			lq_q        <= '0;
			ls_q        <= '0;
			left_q      <= 1'b0;
			first_q     <= 1'b0;
			tbase_q     <= '0;
			pbase_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OPEN_GAP:   open_q <= cfg_data[7:0];
					CFG_EXTEND_GAP: ext_q  <= cfg_data[7:0];
					CFG_DROPOFF:    drop_q <= cfg_data;
					default:        drop_q <= drop_q;
				endcase
			end
			if (rsp_take) rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req.cmd == CMD_START)) begin
						best_q   <= '0;
						bq_q     <= '0;
						bs_q     <= '0;
						thr_q    <= sat(-drop_w);
						q_q      <= '0;
						c_q      <= '0;
						cstart_q <= '0;
						rend_q   <= ls_in;
						lq_q     <= lq_in;
						ls_q     <= ls_in;
						first_q  <= 1'b0;
						left_q   <= 1'b0;
						tbase_q  <= '0;
						pbase_q  <= '0;
					end
				end
				ST_RB: rsp_valid_q <= 1'b1;
				ST_POST: begin
					if (!first_q && (m_q > best_q)) begin
						best_q <= m_q;
						thr_q  <= sat(CW'(m_q) - drop_w);
						bq_q   <= q_q[QW-1:0];
						bs_q   <= c_idx;
					end
					if (row0) begin
						if ((c_q != '0) && row0_brk) begin
							rend_q <= c_inc;
						end
					end else if (first_q) begin
						left_q  <= (thr_q > iq_q);
						first_q <= 1'b0;
						if (thr_q > iq_q) cstart_q <= c_inc;
					end else if (left_q) begin
						if ((thr_q > m_q) && (thr_q > is_q) && (thr_q > iq_q)) begin
							cstart_q <= c_inc;
						end else begin
							left_q <= 1'b0;
						end
					end
					c_q <= c_inc;
					if (row0 && (((c_q != '0) && row0_brk) || (c_inc >= ls_q))) begin
						q_q     <= QC'(1);
						tbase_q <= TAW'(MAX_SUBJECT);
						pbase_q <= PAW'(ALPHABET);
					end
				end
				ST_ROW: begin
					if (row_go) begin
						c_q     <= cstart_q;
						first_q <= 1'b1;
					end else begin
						rsp_valid_q <= 1'b1;
					end
				end
				ST_TCHK: begin
					if (!tail_go) begin
						rend_q  <= c_q;
						q_q     <= q_q + QC'(1);
						tbase_q <= tbase_q + TAW'(MAX_SUBJECT);
						pbase_q <= pbase_q + PAW'(ALPHABET);
					end
				end
				ST_TAIL: begin
					c_q <= c_inc;
					if (tail_stop) begin
						rend_q  <= c_inc;
						q_q     <= q_q + QC'(1);
						tbase_q <= tbase_q + TAW'(MAX_SUBJECT);
						pbase_q <= pbase_q + PAW'(ALPHABET);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Score datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				pen_q    <= open_w;
				rb_oob_q <= (req.query_index >= MAX_QUERY) ||
					(req.subject_index >= MAX_SUBJECT);
			end
			ST_RB: begin
				rsp_q.best_score   <= 23'(best_q);
				rsp_q.best_query   <= 8'(bq_q);
				rsp_q.best_subject <= 10'(bs_q);
				rsp_q.trace_code   <= rb_oob_q ? TR_M_FROM_M : tr_rd;
				rsp_q.is_readback  <= 1'b1;
			end
			ST_PROF: begin
				om_q     <= m_rd;
				oq_q     <= iq_rd;
				os_q     <= is_rd;
				subbig_q <= (sub_rd >= ALPHABET);
			end
			ST_CALC: begin
				m_q  <= m_wd;
				is_q <= is_wd;
				if (!row0) begin
					iq_q  <= iq_wd;
					pom_q <= om_q;
					poq_q <= oq_q;
					pos_q <= os_q;
				end
			end
			ST_POST: begin
				if (row0) begin
					pm_q  <= m_q;
					pis_q <= (c_q == '0) ? Filler : is_q;
					if (c_q != '0) pen_q <= pen_q + ext_w;
				end else if (first_q) begin
					pm_q  <= Filler;
					pis_q <= Filler;
				end else begin
					pm_q  <= m_q;
					pis_q <= is_q;
				end
			end
			ST_ROW: begin
				rsp_q.best_score   <= 23'(best_q);
				rsp_q.best_query   <= 8'(bq_q);
				rsp_q.best_subject <= 10'(bs_q);
				rsp_q.trace_code   <= TR_M_FROM_M;
				rsp_q.is_readback  <= 1'b0;
			end
			ST_TAIL: pis_q <= is_wd;
			default: begin
			end
		endcase
	end
endmodule

// File: src/xage_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module xage_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/xage_checker.sv
// Port-level checker for the gapped extension block, with its bind.
`include "xdrop_affine_gapped_extension_defines.svh"

module xage_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input xage_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input xage_pkg::rsp_t rsp,
	input logic           cfg_we,
	input logic [1:0]     cfg_index,
	input logic [15:0]    cfg_data
);
	import xage_pkg::*;

	`XAGE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
	`XAGE_ASSERT(a_ext_code, rsp_valid && !rsp.is_readback |-> rsp.trace_code == TR_M_FROM_M)
	`XAGE_ASSERT(a_load_silent, req_valid && !req_stall && !rsp_valid && (req.cmd == CMD_LOAD_SUBJECT || req.cmd == CMD_LOAD_PROFILE) |=> !rsp_valid)
	`XAGE_ASSERT(a_busy_out, rsp_valid |-> req_stall)
	`XAGE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid)
endmodule

bind xdrop_affine_gapped_extension xage_checker u_xage_checker (.*);

// File: tb/xage_extension_checker.sv
// Checker for the gapped extension block: predicts every result and compares it.
`timescale 1ns / 1ps
module xage_extension_checker
	import xage_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  req_t           req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  rsp_t           rsp,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output int             mismatches,
	output int             outstanding
);
	localparam int     MQ     = MaxQueryDefault;
	localparam int     MS     = MaxSubjectDefault;
	localparam int     AB     = AlphabetDefault;
	localparam int     SB     = ScoreBitsDefault;
	localparam longint ScMax  = (64'sd1 <<< (SB - 1)) - 1;
	localparam longint ScMin  = -(64'sd1 <<< (SB - 1));
	localparam longint Filler = -(64'sd1 <<< (SB - 2));

	logic [4:0]         letters[MS];
	logic signed [15:0] prof_tab[MQ * AB];
	longint             m_row[MS];
	longint             iy_row[MS];
	longint             ix_row[MS];
	logic [5:0]         trace_tab[MQ * MS];
	bit                 trace_seen[MQ * MS];
	longint             top_score, cut;
	int                 top_q, top_s;
	longint             gap_open, gap_ext, drop_lim;
	rsp_t               pending_answers[$];

	function automatic longint clip(longint v);
		if (v > ScMax) return ScMax;
		if (v < ScMin) return ScMin;
		return v;
	endfunction

	function automatic longint cell_score(int q, int c);
		return longint'(prof_tab[q * AB + int'(letters[c])]);
	endfunction

	function automatic void mark(int q, int c, logic [5:0] t);
		trace_tab[q * MS + c] = t;
		trace_seen[q * MS + c] = 1'b1;
	endfunction

	function automatic void note_best(longint m, int q, int c);
		if (m > top_score) begin
			top_score = m;
			cut = clip(top_score - drop_lim);
			top_q = q;
			top_s = c;
		end
	endfunction

	function automatic void run_extension(int lq, int ls);
		longint     m, pm, pis, pom, poq, pos, om, row_drop, col_drop;
		int         q, c;
		logic [5:0] t;
		bit         left;
		top_score = 0;
		top_q = 0;
		top_s = 0;
		cut = clip(-drop_lim);
		m = cell_score(0, 0);
		m_row[0] = m;
		ix_row[0] = Filler;
		iy_row[0] = Filler;
		mark(0, 0, TR_M_FROM_M);
		note_best(m, 0, 0);
		pm = m;
		pis = Filler;
		row_drop = ls - 1;
		col_drop = -1;
		// First row: only gaps along the subject lead here.
		for (c = 1; c < ls; c++) begin
			m = clip(cell_score(0, c) - gap_open - longint'(c - 1) * gap_ext);
			m_row[c] = m;
			if (clip(pis - gap_ext) > clip(pm - gap_open)) begin
				ix_row[c] = clip(pis - gap_ext);
				t = TR_IX_FROM_IX_1ST;
			end else begin
				ix_row[c] = clip(pm - gap_open);
				t = TR_M_FROM_IX;
			end
			mark(0, c, t);
			iy_row[c] = Filler;
			note_best(m, 0, c);
			if (cut > m && cut > ix_row[c]) begin
				row_drop = c;
				break;
			end
			pm = m;
			pis = ix_row[c];
		end
		for (q = 1; q < lq && row_drop > col_drop; q++) begin
			// The leftmost live cell only carries a gap in the query.
			c = int'(col_drop + 1);
			pom = m_row[c];
			poq = iy_row[c];
			pos = ix_row[c];
			if (clip(poq - gap_ext) > clip(pom - gap_open)) begin
				iy_row[c] = clip(poq - gap_ext);
				mark(q, c, TR_M_IY_FROM_IY);
			end else begin
				iy_row[c] = clip(pom - gap_open);
				mark(q, c, TR_M_FROM_IY);
			end
			m = Filler;
			m_row[c] = Filler;
			ix_row[c] = Filler;
			if (cut > iy_row[c]) begin
				col_drop = c;
				left = 1'b1;
			end else begin
				left = 1'b0;
			end
			pm = m;
			pis = Filler;
			c++;
			while (c <= row_drop) begin
				om = m_row[c];
				if (pom >= poq) begin
					if (pom >= pos) begin
						m = clip(cell_score(q, c) + pom);
						t = TR_M_FROM_M;
					end else begin
						m = clip(cell_score(q, c) + pos);
						t = TR_M_FROM_IX;
					end
				end else begin
					if (poq >= pos) begin
						m = clip(cell_score(q, c) + poq);
						t = TR_M_FROM_IY;
					end else begin
						m = clip(cell_score(q, c) + pos);
						t = TR_M_FROM_IX;
					end
				end
				m_row[c] = m;
				pom = om;
				poq = iy_row[c];
				pos = ix_row[c];
				if (clip(om - gap_open) >= clip(poq - gap_ext)) begin
					iy_row[c] = clip(om - gap_open);
				end else begin
					iy_row[c] = clip(poq - gap_ext);
					t |= TR_IY_FROM_IY;
				end
				if (clip(pm - gap_open) >= clip(pis - gap_ext)) begin
					ix_row[c] = clip(pm - gap_open);
				end else begin
					ix_row[c] = clip(pis - gap_ext);
					t |= TR_IX_FROM_IX;
				end
				mark(q, c, t);
				note_best(m, q, c);
				if (left) begin
					if (cut > m && cut > ix_row[c] && cut > iy_row[c])
						col_drop = c;
					else
						left = 1'b0;
				end
				pm = m;
				pis = ix_row[c];
				c++;
			end
			// Past the row dropoff only the subject gap keeps running.
			if (!(cut > pm && cut > pis && cut > iy_row[c - 1])) begin
				while (c < ls) begin
					ix_row[c] = clip(pis - gap_ext);
					mark(q, c, TR_IX_FROM_IX);
					m_row[c] = Filler;
					iy_row[c] = Filler;
					if (cut > ix_row[c]) begin
						c++;
						break;
					end
					pis = ix_row[c];
					c++;
				end
			end
			row_drop = c - 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   lq, ls;
		if (!arst_n) begin
			gap_open = OpenGapReset;
			gap_ext = ExtendGapReset;
			drop_lim = DropoffReset;
			top_score = 0;
			top_q = 0;
			top_s = 0;
			pending_answers.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_answers.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected: %p", $realtime, rsp);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_answers.pop_front();
					if (rsp !== want) begin
						if (mismatches < 10)
							$display("%0t: expected %p, got %p", $realtime, want, rsp);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req_valid && !req_stall) begin
				case (req.cmd)
					CMD_LOAD_SUBJECT: letters[int'(req.subject_index)] = req.residue;
					CMD_LOAD_PROFILE:
						prof_tab[int'(req.query_index) * AB + int'(req.residue)] = req.score;
					CMD_START: begin
						lq = int'(req.query_length);
						ls = int'(req.subject_length);
						if (lq == 0) lq = 1;
						if (ls == 0) ls = 1;
						if (lq > MQ) lq = MQ;
						if (ls > MS) ls = MS;
						run_extension(lq, ls);
						want.best_score = top_score[22:0];
						want.best_query = top_q[7:0];
						want.best_subject = top_s[9:0];
						want.trace_code = '0;
						want.is_readback = 1'b0;
						pending_answers.push_back(want);
					end
					default: begin
						want.best_score = top_score[22:0];
						want.best_query = top_q[7:0];
						want.best_subject = top_s[9:0];
						want.trace_code =
							trace_tab[int'(req.query_index) * MS + int'(req.subject_index)];
						want.is_readback = 1'b1;
						pending_answers.push_back(want);
					end
				endcase
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_OPEN_GAP:   gap_open = cfg_data[7:0];
					CFG_EXTEND_GAP: gap_ext = cfg_data[7:0];
					CFG_DROPOFF:    drop_lim = cfg_data;
					default: ;
				endcase
			end
			outstanding <= pending_answers.size();
		end
	end
endmodule

// File: tb/tb.sv
// Testbench top: drives loads, extensions and traceback reads into the gapped extension block.
`timescale 1ns / 1ps
module tb;
	import xage_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          mismatches, outstanding;

	int          gap_pct = 0;
	int          stall_pct = 0;
	int          last_lq = 0;
	int          last_ls = 0;
	bit          subj_known[1024];
	logic [4:0]  subj_val[1024];
	bit          prof_known[8192];

	xdrop_affine_gapped_extension dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	xage_extension_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic req_t noise();
		req_t r;
		r.cmd = cmd_t'($urandom_range(3));
		r.query_index = $urandom;
		r.subject_index = $urandom;
		r.residue = $urandom;
		r.score = $urandom;
		r.query_length = $urandom;
		r.subject_length = $urandom;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_score();
		int k;
		k = $urandom_range(99);
		if (k < 70) return 16'(int'($urandom_range(24)) - 12);
		if (k < 75) return 16'sh7fff;
		if (k < 80) return 16'sh8000;
		return $urandom;
	endfunction

	task automatic send(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic load_letter(input int i, input logic [4:0] v);
		req_t r;
		r = noise();
		r.cmd = CMD_LOAD_SUBJECT;
		r.subject_index = i;
		r.residue = v;
		subj_known[i] = 1'b1;
		subj_val[i] = v;
		send(r);
	endtask

	task automatic load_prof(input int q, input int a, input logic signed [15:0] s);
		req_t r;
		r = noise();
		r.cmd = CMD_LOAD_PROFILE;
		r.query_index = q;
		r.residue = a;
		r.score = s;
		prof_known[q * 32 + a] = 1'b1;
		send(r);
	endtask

	// Loads every store entry the extension may touch that is not yet written, before issuing it.
	task automatic start(input int lq_raw, input int ls_raw);
		req_t r;
		int   lq, ls;
		lq = (lq_raw == 0) ? 1 : (lq_raw > 256 ? 256 : lq_raw);
		ls = (ls_raw == 0) ? 1 : (ls_raw > 1024 ? 1024 : ls_raw);
		for (int c = 0; c < ls; c++)
			if (!subj_known[c]) load_letter(c, $urandom_range(7));
		for (int q = 0; q < lq; q++)
			for (int c = 0; c < ls; c++)
				if (!prof_known[q * 32 + subj_val[c]]) load_prof(q, subj_val[c], pick_score());
		r = noise();
		r.cmd = CMD_START;
		r.query_length = lq_raw;
		r.subject_length = ls_raw;
		last_lq = lq;
		last_ls = ls;
		send(r);
	endtask

	// Reads only cells that the last extensions have covered.
	task automatic read_back();
		req_t r;
		int   q, c;
		bit   found;
		found = 1'b0;
		for (int k = 0; k < 20 && !found && last_lq > 0; k++) begin
			q = $urandom_range(last_lq - 1);
			c = $urandom_range(last_ls - 1);
			found = u_chk.trace_seen[q * 1024 + c];
		end
		if (!found && last_lq > 0) begin
			q = 0;
			c = 0;
			found = 1'b1;
		end
		if (found) begin
			r = noise();
			r.cmd = CMD_READ_TRACE;
			r.query_index = q;
			r.subject_index = c;
			send(r);
		end
	endtask

	task automatic set_cfg(input int og, input int eg, input int dl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OPEN_GAP;
		cfg_data <= og;
		@(posedge clk);
		cfg_index <= CFG_EXTEND_GAP;
		cfg_data <= eg;
		@(posedge clk);
		cfg_index <= CFG_DROPOFF;
		cfg_data <= dl;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int gp, input int sp);
		int k;
		gap_pct = gp;
		stall_pct = sp;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 40)
				load_letter($urandom_range(1023),
					($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(7));
			else if (k < 70)
				load_prof($urandom_range(255), $urandom_range(31), pick_score());
			else if (k < 85)
				start($urandom_range(1, 12), $urandom_range(1, 24));
			else
				read_back();
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_cfg(OpenGapReset, ExtendGapReset, DropoffReset);

		// Directed part: field extremes, zero and oversized lengths, readbacks.
		load_letter(0, 5'd31);
		load_letter(1023, 5'd0);
		load_prof(255, 31, 16'sh8000);
		load_prof(0, 31, 16'sh7fff);
		start(0, 0);
		read_back();
		load_letter(1, 5'd31);
		load_prof(1, 31, 16'sh7fff);
		start(4, 6);
		read_back();
		read_back();
		start(511, 3);
		read_back();
		start(2, 2047);
		read_back();
		start(300, 1);
		read_back();
		drain();

		set_cfg(0, 0, 16'hffff);
		run_phase(112, 0, 0);
		set_cfg(255, 255, 0);
		run_phase(112, 45, 0);
		set_cfg($urandom_range(255), $urandom_range(255), $urandom_range(200));
		run_phase(112, 0, 45);
		set_cfg($urandom_range(20), $urandom_range(4), $urandom_range(20, 80));
		run_phase(112, 7, 7);
		stall_pct = 0;
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: files.f
+incdir+src
src/xage_pkg.sv
src/xage_ram.sv
src/xdrop_affine_gapped_extension.sv
src/xage_checker.sv
tb/xage_extension_checker.sv
tb/tb.sv
